FILE: sv/setw_pkg.sv
package setw_pkg;

    // request codes
    localparam logic [2:0] OP_GAIN     = 3'd0;
    localparam logic [2:0] OP_EXPOSURE = 3'd1;
    localparam logic [2:0] OP_FRAME    = 3'd2;
    localparam logic [2:0] OP_HOLD     = 3'd3;
    localparam logic [2:0] OP_MODE     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_WRITE   = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_MODE    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_PCLK   = 3'd0;
    localparam logic [2:0] CFG_LLEN   = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_FSCALE = 3'd3;
    localparam logic [2:0] CFG_ESCALE = 3'd4;
    localparam logic [2:0] CFG_MINGN  = 3'd5;
    localparam logic [2:0] CFG_MAXGN  = 3'd6;

    // sensor register addresses and codes
    localparam logic [15:0] ADDR_GAIN_HI = 16'h350a;
    localparam logic [15:0] ADDR_GAIN_LO = 16'h350b;
    localparam logic [15:0] ADDR_EXP_HI  = 16'h3500;
    localparam logic [15:0] ADDR_EXP_MID = 16'h3501;
    localparam logic [15:0] ADDR_EXP_LO  = 16'h3502;
    localparam logic [15:0] ADDR_FL_HI   = 16'h380e;
    localparam logic [15:0] ADDR_FL_LO   = 16'h380f;
    localparam logic [15:0] ADDR_HOLD    = 16'h3208;
    localparam logic [7:0]  HOLD_START   = 8'h00;
    localparam logic [7:0]  HOLD_END     = 8'h10;
    localparam logic [7:0]  HOLD_LAUNCH  = 8'ha0;

    // limits
    localparam logic [15:0] GAIN_FLOOR = 16'd16;
    localparam logic [15:0] GAIN_CEIL  = 16'd1023;
    localparam logic [12:0] FL_MARGIN  = 13'd24;
    localparam logic [14:0] FL_MAX     = 15'h7fff;
    localparam logic [14:0] EXP_MIN    = 15'd4;

    // shared unit step counts
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 16;

    // configuration reset values
    localparam logic [31:0] RST_PCLK   = 32'd160000000;
    localparam logic [15:0] RST_LLEN   = 16'd2416;
    localparam logic [11:0] RST_HEIGHT = 12'd1944;
    localparam logic [19:0] RST_FSCALE = 20'd1000000;
    localparam logic [19:0] RST_ESCALE = 20'd1000000;
    localparam logic [15:0] RST_MINGN  = 16'd16;
    localparam logic [15:0] RST_MAXGN  = 16'd1023;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [2:0]         mode_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] reg_address;
        logic [7:0]  reg_data;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] pixel_clock_hz;
        logic [15:0] line_length_pixels;
        logic [11:0] active_height_lines;
        logic [19:0] frame_rate_scale;
        logic [19:0] exposure_scale;
        logic [15:0] min_gain;
        logic [15:0] max_gain;
    } t_cfg;

    // default frame length per mode
    function automatic logic [14:0] mode_frame_length(input logic [2:0] mode);
        logic [14:0] fl;
        case (mode)
            3'd1:    fl = 15'h0450;
            3'd2:    fl = 15'h059b;
            3'd3:    fl = 15'h01f8;
            default: fl = 15'h07b0;
        endcase
        return fl;
    endfunction

endpackage

FILE: sv/setw_alu.sv
module setw_alu (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_sub,
    output logic [63:0] o_sum,
    output logic        o_carry
);

    logic [64:0] w_full;

    // carry out on subtract means a >= b
    assign w_full  = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {64'b0, i_sub};
    assign o_sum   = w_full[63:0];
    assign o_carry = w_full[64];

endmodule

FILE: sv/setw_core.sv
module setw_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  setw_pkg::t_cfg   i_cfg,
    input  logic             i_in_valid,
    input  setw_pkg::t_in_item i_in,
    output logic             o_idle,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output setw_pkg::t_out_item o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MULD  = 3'd1;
    localparam logic [2:0] S_MULN  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_CLAMP = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_op, n_op;
    logic [31:0] r_raw, n_raw;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_mc, n_mc;
    logic [31:0] r_mp, n_mp;
    logic [46:0] r_den, n_den;
    logic [15:0] r_q, n_q;
    logic [15:0] r_res, n_res;
    logic [14:0] r_fl, n_fl;
    logic [1:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    setw_pkg::t_out_item r_out, n_out;

    logic [63:0] w_alu_b;
    logic        w_alu_sub;
    logic [63:0] w_alu_sum;
    logic        w_alu_carry;
    logic [63:0] w_mul_acc;
    logic        w_in_pos;
    logic        w_pos;
    logic [15:0] w_gain;
    logic [15:0] w_gain_lim;
    logic [14:0] w_ceil;
    logic [15:0] w_lines;
    logic [12:0] w_fl_lo;
    logic [15:0] w_fl;
    logic        w_load;
    setw_pkg::t_out_item w_beat;

    setw_alu u_alu (
        .i_a     (r_acc),
        .i_b     (w_alu_b),
        .i_sub   (w_alu_sub),
        .o_sum   (w_alu_sum),
        .o_carry (w_alu_carry)
    );

    assign w_alu_b   = (r_state == S_CHK) ? {1'b0, r_den, 16'b0} : r_mc;
    assign w_alu_sub = (r_state == S_CHK) || (r_state == S_DIV);
    assign w_mul_acc = r_mp[0] ? w_alu_sum : r_acc;
    assign w_in_pos  = !i_in.value[31] && (i_in.value != 32'sd0);
    assign w_pos     = !r_raw[31] && (r_raw != 32'd0);

    // gain: configured limits first, then the fixed range
    always_comb begin
        if (i_in.value[31] || (32'(i_in.value) < {16'b0, i_cfg.min_gain})) begin
            w_gain = i_cfg.min_gain;
        end else if (32'(i_in.value) > {16'b0, i_cfg.max_gain}) begin
            w_gain = i_cfg.max_gain;
        end else begin
            w_gain = i_in.value[15:0];
        end
        if (w_gain < setw_pkg::GAIN_FLOOR) begin
            w_gain_lim = setw_pkg::GAIN_FLOOR;
        end else if (w_gain > setw_pkg::GAIN_CEIL) begin
            w_gain_lim = setw_pkg::GAIN_CEIL;
        end else begin
            w_gain_lim = w_gain;
        end
    end

    // quotient clamps
    always_comb begin
        w_ceil = (r_fl > setw_pkg::EXP_MIN) ? (r_fl - setw_pkg::EXP_MIN) : setw_pkg::EXP_MIN;
        if (r_q < {1'b0, setw_pkg::EXP_MIN}) begin
            w_lines = {1'b0, setw_pkg::EXP_MIN};
        end else if (r_q > {1'b0, w_ceil}) begin
            w_lines = {1'b0, w_ceil};
        end else begin
            w_lines = r_q;
        end
        w_fl_lo = {1'b0, i_cfg.active_height_lines} + setw_pkg::FL_MARGIN;
        if (r_q < {3'b0, w_fl_lo}) begin
            w_fl = {3'b0, w_fl_lo};
        end else if (r_q > {1'b0, setw_pkg::FL_MAX}) begin
            w_fl = {1'b0, setw_pkg::FL_MAX};
        end else begin
            w_fl = r_q;
        end
    end

    // beat for the current result index
    always_comb begin
        w_beat = '0;
        w_beat.status = setw_pkg::ST_WRITE;
        case (r_op)
            setw_pkg::OP_GAIN: begin
                if (r_idx == 2'd0) begin
                    w_beat.reg_address = setw_pkg::ADDR_GAIN_HI;
                    w_beat.reg_data    = {6'b0, r_res[9:8]};
                end else begin
                    w_beat.reg_address = setw_pkg::ADDR_GAIN_LO;
                    w_beat.reg_data    = r_res[7:0];
                    w_beat.last        = 1'b1;
                end
            end
            setw_pkg::OP_EXPOSURE: begin
                if (!w_pos) begin
                    w_beat.status = setw_pkg::ST_INVALID;
                    w_beat.last   = 1'b1;
                end else if (r_idx == 2'd0) begin
                    w_beat.reg_address = setw_pkg::ADDR_EXP_HI;
                    w_beat.reg_data    = {4'b0, r_res[15:12]};
                end else if (r_idx == 2'd1) begin
                    w_beat.reg_address = setw_pkg::ADDR_EXP_MID;
                    w_beat.reg_data    = r_res[11:4];
                end else begin
                    w_beat.reg_address = setw_pkg::ADDR_EXP_LO;
                    w_beat.reg_data    = {r_res[3:0], 4'b0};
                    w_beat.last        = 1'b1;
                end
            end
            setw_pkg::OP_FRAME: begin
                if (!w_pos) begin
                    w_beat.status = setw_pkg::ST_INVALID;
                    w_beat.last   = 1'b1;
                end else if (r_idx == 2'd0) begin
                    w_beat.reg_address = setw_pkg::ADDR_FL_HI;
                    w_beat.reg_data    = r_res[15:8];
                end else begin
                    w_beat.reg_address = setw_pkg::ADDR_FL_LO;
                    w_beat.reg_data    = r_res[7:0];
                    w_beat.last        = 1'b1;
                end
            end
            setw_pkg::OP_HOLD: begin
                w_beat.reg_address = setw_pkg::ADDR_HOLD;
                if (r_raw != 32'd0) begin
                    w_beat.reg_data = setw_pkg::HOLD_START;
                    w_beat.last     = 1'b1;
                end else if (r_idx == 2'd0) begin
                    w_beat.reg_data = setw_pkg::HOLD_END;
                end else begin
                    w_beat.reg_data = setw_pkg::HOLD_LAUNCH;
                    w_beat.last     = 1'b1;
                end
            end
            setw_pkg::OP_MODE: begin
                w_beat.status = setw_pkg::ST_MODE;
                w_beat.last   = 1'b1;
            end
            default: begin
                w_beat.status = setw_pkg::ST_INVALID;
                w_beat.last   = 1'b1;
            end
        endcase
    end

    assign w_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_raw   = r_raw;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_mc    = r_mc;
        n_mp    = r_mp;
        n_den   = r_den;
        n_q     = r_q;
        n_res   = r_res;
        n_fl    = r_fl;
        n_idx   = r_idx;
        n_out   = r_out;
        n_out_valid = (r_out_valid && !i_out_stall) ? 1'b0 : r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in.operation;
                    n_raw = 32'(i_in.value);
                    n_idx = 2'd0;
                    n_acc = '0;
                    n_cnt = '0;
                    n_state = S_EMIT;
                    case (i_in.operation)
                        setw_pkg::OP_GAIN: begin
                            n_res = w_gain_lim;
                        end
                        setw_pkg::OP_EXPOSURE: begin
                            // denominator: exposure scale times line length
                            n_mc = {44'b0, i_cfg.exposure_scale};
                            n_mp = {16'b0, i_cfg.line_length_pixels};
                            if (w_in_pos) begin
                                n_state = S_MULD;
                            end
                        end
                        setw_pkg::OP_FRAME: begin
                            // denominator: rate times line length
                            n_mc = {32'b0, 32'(i_in.value)};
                            n_mp = {16'b0, i_cfg.line_length_pixels};
                            if (w_in_pos) begin
                                n_state = S_MULD;
                            end
                        end
                        setw_pkg::OP_MODE: begin
                            n_fl = setw_pkg::mode_frame_length(i_in.mode_index);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MULD, S_MULN: begin
                n_acc = w_mul_acc;
                n_mc  = {r_mc[62:0], 1'b0};
                n_mp  = {1'b0, r_mp[31:1]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(setw_pkg::MUL_STEPS - 1)) begin
                    n_cnt = '0;
                    if (r_state == S_MULD) begin
                        n_den = w_mul_acc[46:0];
                        n_acc = '0;
                        if (r_op == setw_pkg::OP_EXPOSURE) begin
                            n_mc = {32'b0, r_raw};
                            n_mp = i_cfg.pixel_clock_hz;
                        end else begin
                            n_mc = {32'b0, i_cfg.pixel_clock_hz};
                            n_mp = {12'b0, i_cfg.frame_rate_scale};
                        end
                        n_state = S_MULN;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                // quotient of 2^16 or more (or zero divisor) saturates
                if (w_alu_carry) begin
                    n_q     = 16'hffff;
                    n_state = S_CLAMP;
                end else begin
                    n_mc    = {2'b0, r_den, 15'b0};
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_alu_carry) begin
                    n_acc = w_alu_sum;
                end
                n_q   = {r_q[14:0], w_alu_carry};
                n_mc  = {1'b0, r_mc[63:1]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(setw_pkg::DIV_STEPS - 1)) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (r_op == setw_pkg::OP_FRAME) begin
                    n_res = w_fl;
                    n_fl  = w_fl[14:0];
                end else begin
                    n_res = w_lines;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_out       = w_beat;
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + 2'd1;
                    if (w_beat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fl        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fl        <= n_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_raw <= n_raw;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
        r_den <= n_den;
        r_q   <= n_q;
        r_res <= n_res;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: sv/sensor_exposure_timing_writer_top.sv
// sensor exposure, gain and frame timing register writer
//
// input channel i_in_valid / o_in_stall carries one request (operation, value,
// mode_index); output channel o_out_valid / i_out_stall carries one sensor
// register write per beat (address, data, status, last), last marking the
// final beat of a request. configuration is a plain write port
// (i_cfg_we, i_cfg_index, i_cfg_data) taken at any edge with i_cfg_we high outside reset.
//
// one request is in flight at a time; o_in_stall is high from acceptance
// until its last beat is loaded into the output register.
// gain, group hold, select mode and rejected requests go from acceptance straight
// to the emit state; a two-beat request frees the input once its second beat is loaded.
// exposure and frame rate: one shared 64-bit adder does two 32-step shift-add
// multiplies, a range check and a 16-step restoring divide before the first beat
// is emitted (the divide is skipped when the quotient saturates); an exposure
// request has three beats.
// further beats follow one per cycle while i_out_stall is low.
// a stalled output beat holds its register and the sequencer waits.
// reset (synchronous, active low) restores default configuration, clears
// the stored frame length to 0 and empties the output register.
module sensor_exposure_timing_writer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  setw_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output setw_pkg::t_out_item o_out
);

    setw_pkg::t_cfg r_cfg;
    logic           w_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_clock_hz      <= setw_pkg::RST_PCLK;
            r_cfg.line_length_pixels  <= setw_pkg::RST_LLEN;
            r_cfg.active_height_lines <= setw_pkg::RST_HEIGHT;
            r_cfg.frame_rate_scale    <= setw_pkg::RST_FSCALE;
            r_cfg.exposure_scale      <= setw_pkg::RST_ESCALE;
            r_cfg.min_gain            <= setw_pkg::RST_MINGN;
            r_cfg.max_gain            <= setw_pkg::RST_MAXGN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                setw_pkg::CFG_PCLK:   r_cfg.pixel_clock_hz      <= i_cfg_data;
                setw_pkg::CFG_LLEN:   r_cfg.line_length_pixels  <= i_cfg_data[15:0];
                setw_pkg::CFG_HEIGHT: r_cfg.active_height_lines <= i_cfg_data[11:0];
                setw_pkg::CFG_FSCALE: r_cfg.frame_rate_scale    <= i_cfg_data[19:0];
                setw_pkg::CFG_ESCALE: r_cfg.exposure_scale      <= i_cfg_data[19:0];
                setw_pkg::CFG_MINGN:  r_cfg.min_gain            <= i_cfg_data[15:0];
                setw_pkg::CFG_MAXGN:  r_cfg.max_gain            <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // no requests taken while in reset
    assign o_in_stall = !w_idle || !i_rst_n;

    setw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid && i_rst_n),
        .i_in        (i_in),
        .o_idle      (w_idle),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but sequencer did not go busy");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && w_idle))
        else $error("reset did not empty output and idle the sequencer");

    a_nonwrite_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != setw_pkg::ST_WRITE)) |-> o_out.last)
        else $error("non-write result beat is not the last beat");

    a_frame_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.reg_address == setw_pkg::ADDR_FL_HI))
            |-> !o_out.reg_data[7])
        else $error("frame length high byte exceeds 15-bit range");

endmodule
